// ===== hdl/ftg_pkg.sv =====
package ftg_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned CordicFrac  = 30;

  localparam int unsigned NumW   = 64;
  localparam int unsigned DenW   = 32;
  localparam int unsigned MulAW  = 34;
  localparam int unsigned MulBW  = 26;
  localparam int unsigned ProdW  = 60;
  localparam int unsigned SumW   = 62;
  localparam int unsigned AngW   = 34;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegShape = 3'd0;
  localparam logic [CfgIdxW-1:0] RegX1    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegX2    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegX3    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegY1    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegY2    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegSpeed = 3'd6;

  localparam logic [23:0] SpeedReset = 24'd65536;
  localparam logic [31:0] PiQ30      = 32'd3373259426;
  localparam logic [31:0] HalfPiQ30  = 32'd1686629713;
  localparam logic [31:0] GainQ30    = 32'd652032874;

  typedef struct packed {
    logic [23:0] time_now;
  } ftg_in_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [23:0]        time_used;
    logic [1:0]         segment;
    logic               fault;
  } ftg_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [23:0]        value;
  } ftg_cfg_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [NumW-1:0] quo;
  } div_rsp_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0:  return 32'h3243F6A8;
      5'd1:  return 32'h1DAC6705;
      5'd2:  return 32'h0FADBAFC;
      5'd3:  return 32'h07F56EA6;
      5'd4:  return 32'h03FEAB76;
      5'd5:  return 32'h01FFD55B;
      5'd6:  return 32'h00FFFAAA;
      5'd7:  return 32'h007FFF55;
      5'd8:  return 32'h003FFFEA;
      5'd9:  return 32'h001FFFFD;
      5'd10: return 32'h000FFFFF;
      5'd11: return 32'h0007FFFF;
      5'd12: return 32'h0003FFFF;
      5'd13: return 32'h0001FFFF;
      5'd14: return 32'h0000FFFF;
      5'd15: return 32'h00007FFF;
      5'd16: return 32'h00003FFF;
      5'd17: return 32'h00001FFF;
      5'd18: return 32'h00000FFF;
      5'd19: return 32'h000007FF;
      5'd20: return 32'h000003FF;
      5'd21: return 32'h000001FF;
      5'd22: return 32'h000000FF;
      5'd23: return 32'h0000007F;
      default: return 32'h0;
    endcase
  endfunction

  function automatic logic [24:0] abs25(input logic signed [24:0] v);
    return v[24] ? 25'(-v) : 25'(v);
  endfunction

  function automatic logic [23:0] sat_u24(input logic [NumW-1:0] v);
    return (|v[NumW-1:24]) ? 24'hFFFFFF : v[23:0];
  endfunction

  function automatic logic [23:0] sat_s24(input logic signed [SumW-1:0] v);
    if (v > SumW'(signed'(25'sd8388607))) return 24'h7FFFFF;
    if (v < SumW'(-signed'(25'sd8388608))) return 24'h800000;
    return v[23:0];
  endfunction

  function automatic logic [31:0] slope_fix(input logic [NumW-1:0] q, input logic neg);
    if (!neg && (|q[NumW-1:31])) return 32'h7FFFFFFF;
    if (neg && ((|q[NumW-1:32]) || (q[31] && (|q[30:0])))) return 32'h80000000;
    return neg ? 32'(-q[31:0]) : q[31:0];
  endfunction

endpackage

// ===== hdl/ftg_stream_if.sv =====
interface ftg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/foot_trajectory_generator.sv =====
// Foot trajectory generator: each time_now beat returns one result beat with the foot X/Y
// position, the time used (zeroed past the route end), the segment and a fault flag on a
// triangle or half-ellipse route set by the configuration registers. Multiplication runs
// on one shared 34x26 multiplier, division on one radix-2 divider and the rotation on one
// CORDIC stage stepped CORDIC_STEPS times. A triangle or stroke sample needs no division;
// a sample on the half ellipse takes one division plus CORDIC_STEPS rotations. The first
// sample after reset or after a register write first rederives timings and slopes: seven
// divisions for the triangle and two for the ellipse.
// The configuration channel is always ready; input ready is high only between samples.
module foot_trajectory_generator import ftg_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CordicSteps,
  parameter int unsigned FRAC_BITS    = FracBits
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ftg_stream_if.sink   in_i,
  ftg_stream_if.source out_o,
  ftg_stream_if.sink   cfg_i
);

  localparam int unsigned CiW = $clog2(CORDIC_STEPS);

  typedef enum logic [4:0] {
    S_IDLE, S_RC, S_T1, S_T2M, S_T2S, S_T2, S_SLP, S_PER, S_KE, S_POS,
    S_PHM, S_PHS, S_PHI, S_CORD, S_MUL1, S_MUL2, S_MUL3, S_FIN
  } state_e;

  state_e state_q;

  logic               shape_q;
  logic signed [23:0] x1_q, x2_q, x3_q, y1_q, y2_q;
  logic [23:0]        speed_q;
  logic               recomp_q;
  logic               fault_q;
  logic [23:0]        t1_q, t2_q, t3_q, per_q, a_q, b_q;
  logic signed [31:0] kx1_q, kx2_q, kx3_q, ky1_q, ky2_q, k_q;
  logic [2:0]         sl_q;
  logic               slneg_q;
  div_req_t           div_req_q;
  div_rsp_t           div_rsp;

  logic [23:0]        t_q;
  logic [1:0]         seg_q;
  logic signed [23:0] px_q, py_q;
  logic signed [ProdW-1:0] mul_q;
  logic signed [AngW-1:0]  cx_q, cy_q, cz_q;
  logic [CiW-1:0]     ci_q;
  logic               out_valid_q;
  ftg_out_t           out_q;

  ftg_div #(.NUM_W(NumW), .DEN_W(DenW)) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req_q),
    .rsp_o (div_rsp)
  );

  logic signed [24:0] d21, d32, d13, dy;
  logic [24:0]        dxm, ra, rb, dym;
  logic [25:0]        rsum;
  assign d21  = 25'(x2_q) - 25'(x1_q);
  assign d32  = 25'(x3_q) - 25'(x2_q);
  assign d13  = 25'(x1_q) - 25'(x3_q);
  assign dy   = 25'(y2_q) - 25'(y1_q);
  assign dxm  = abs25(d21);
  assign ra   = abs25(d32);
  assign rb   = abs25(d13);
  assign dym  = abs25(dy);
  assign rsum = {1'b0, ra} + {1'b0, rb};

  logic [2:0]         sl_sel;
  logic signed [24:0] sl_num;
  logic [23:0]        sl_den;
  assign sl_sel = (state_q == S_SLP) ? 3'(sl_q + 3'd1) : 3'd0;
  always_comb begin
    case (sl_sel)
      3'd0:    begin sl_num = d21;      sl_den = t1_q;        end
      3'd1:    begin sl_num = d32;      sl_den = t2_q - t1_q; end
      3'd2:    begin sl_num = d13;      sl_den = t3_q - t2_q; end
      3'd3:    begin sl_num = dy;       sl_den = t2_q - t1_q; end
      default: begin sl_num = 25'(-dy); sl_den = t3_q - t2_q; end
    endcase
  end

  logic [23:0] t1_w, t2_w, t3_w, per_w;
  logic [31:0] slope_w;
  assign t1_w    = sat_u24(div_rsp.quo);
  assign t2_w    = sat_u24(NumW'(t1_q) + div_rsp.quo);
  assign t3_w    = sat_u24(NumW'(t1_q) << 1);
  assign per_w   = sat_u24(div_rsp.quo);
  assign slope_w = slope_fix(div_rsp.quo, slneg_q);

  logic [23:0] t_tri, t_ell;
  logic [1:0]  seg_tri;
  logic        seg_ell;
  assign t_tri   = (t_q > t3_q) ? 24'd0 : t_q;
  assign seg_tri = (t_tri < t1_q) ? 2'd0 : ((t_tri < t2_q) ? 2'd1 : 2'd2);
  assign t_ell   = (t_q > per_q) ? 24'd0 : t_q;
  assign seg_ell = !({t_ell, 1'b0} < {1'b0, per_q});

  logic [24:0]        d2t;
  logic signed [24:0] dt_x, dt_y;
  logic               ell1;
  assign d2t  = {t_q, 1'b0} - {1'b0, per_q};
  assign ell1 = shape_q && (seg_q == 2'd1);
  always_comb begin
    case (seg_q)
      2'd0:    dt_x = signed'({1'b0, t_q}) - signed'({1'b0, t1_q});
      2'd1:    dt_x = signed'({1'b0, t_q}) - signed'({1'b0, t2_q});
      default: dt_x = signed'({1'b0, t_q}) - signed'({1'b0, t3_q});
    endcase
    dt_y = (seg_q == 2'd1) ? signed'({1'b0, t_q}) - signed'({1'b0, t2_q})
                           : signed'({1'b0, t_q}) - signed'({1'b0, t3_q});
  end

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_T2M: begin
        mul_a = MulAW'({1'b0, ra});
        mul_b = MulBW'({1'b0, t1_q});
      end
      S_PHM: begin
        mul_a = MulAW'({1'b0, PiQ30});
        mul_b = MulBW'({1'b0, d2t});
      end
      S_MUL1: begin
        if (ell1) begin
          mul_a = cy_q;
          mul_b = MulBW'({1'b0, a_q});
        end else if (shape_q) begin
          mul_a = MulAW'(k_q);
          mul_b = MulBW'({1'b0, t_q});
        end else begin
          case (seg_q)
            2'd0:    mul_a = MulAW'(kx1_q);
            2'd1:    mul_a = MulAW'(kx2_q);
            default: mul_a = MulAW'(kx3_q);
          endcase
          mul_b = MulBW'(dt_x);
        end
      end
      S_MUL2: begin
        if (ell1) begin
          mul_a = cx_q;
          mul_b = MulBW'({1'b0, b_q});
        end else if (!shape_q && seg_q != 2'd0) begin
          mul_a = (seg_q == 2'd1) ? MulAW'(ky1_q) : MulAW'(ky2_q);
          mul_b = MulBW'(dt_y);
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  logic signed [ProdW-1:0] mul_full, prod_f, prod_c;
  assign mul_full = mul_a * mul_b;
  assign prod_f   = mul_q >>> FRAC_BITS;
  assign prod_c   = mul_q >>> CordicFrac;

  logic signed [23:0]     base_x, base_y;
  logic signed [SumW-1:0] x_sum, y_sum;
  always_comb begin
    if (shape_q) begin
      base_x = x1_q;
      base_y = y1_q;
    end else begin
      case (seg_q)
        2'd0:    begin base_x = x2_q; base_y = y1_q; end
        2'd1:    begin base_x = x3_q; base_y = y2_q; end
        default: begin base_x = x1_q; base_y = y1_q; end
      endcase
    end
    if (ell1) begin
      x_sum = SumW'(x1_q) - SumW'(signed'({1'b0, a_q})) + SumW'(prod_c);
      y_sum = SumW'(y1_q) - SumW'(prod_c);
    end else begin
      x_sum = SumW'(base_x) + SumW'(prod_f);
      y_sum = SumW'(base_y) + SumW'(prod_f);
    end
  end

  logic signed [AngW-1:0] theta, cdx, cdy, cat;
  assign theta = {2'b0, div_rsp.quo[31:0]} - {2'b0, HalfPiQ30};
  assign cdx   = cy_q >>> ci_q;
  assign cdy   = cx_q >>> ci_q;
  assign cat   = {2'b0, atan_q30(5'(ci_q))};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      shape_q         <= 1'b0;
      x1_q            <= '0;
      x2_q            <= '0;
      x3_q            <= '0;
      y1_q            <= '0;
      y2_q            <= '0;
      speed_q         <= SpeedReset;
      recomp_q        <= 1'b1;
      fault_q         <= 1'b0;
      t1_q            <= '0;
      t2_q            <= '0;
      t3_q            <= '0;
      per_q           <= '0;
      a_q             <= '0;
      b_q             <= '0;
      kx1_q           <= '0;
      kx2_q           <= '0;
      kx3_q           <= '0;
      ky1_q           <= '0;
      ky2_q           <= '0;
      k_q             <= '0;
      sl_q            <= '0;
      div_req_q.start <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      div_req_q.start <= 1'b0;
      mul_q           <= mul_full;
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_i.valid) begin
        case (cfg_i.data.index)
          RegShape: begin shape_q <= cfg_i.data.value[0]; recomp_q <= 1'b1; end
          RegX1:    begin x1_q    <= cfg_i.data.value;    recomp_q <= 1'b1; end
          RegX2:    begin x2_q    <= cfg_i.data.value;    recomp_q <= 1'b1; end
          RegX3:    begin x3_q    <= cfg_i.data.value;    recomp_q <= 1'b1; end
          RegY1:    begin y1_q    <= cfg_i.data.value;    recomp_q <= 1'b1; end
          RegY2:    begin y2_q    <= cfg_i.data.value;    recomp_q <= 1'b1; end
          RegSpeed: begin speed_q <= cfg_i.data.value;    recomp_q <= 1'b1; end
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            t_q     <= in_i.data.time_now;
            state_q <= recomp_q ? S_RC : S_POS;
          end
        end
        S_RC: begin
          recomp_q <= 1'b0;
          fault_q  <= 1'b0;
          if (speed_q == '0) begin
            fault_q <= 1'b1;
            state_q <= S_POS;
          end else if (!shape_q) begin
            if (rsum == '0) begin
              fault_q <= 1'b1;
              state_q <= S_POS;
            end else begin
              div_req_q.start <= 1'b1;
              div_req_q.num   <= NumW'(dxm) << FRAC_BITS;
              div_req_q.den   <= DenW'(speed_q);
              state_q         <= S_T1;
            end
          end else begin
            a_q             <= dxm[24:1];
            b_q             <= dym[23:0];
            div_req_q.start <= 1'b1;
            div_req_q.num   <= NumW'(dxm) << (FRAC_BITS + 1);
            div_req_q.den   <= DenW'(speed_q);
            state_q         <= S_PER;
          end
        end
        S_T1: begin
          if (div_rsp.done) begin
            t1_q    <= t1_w;
            state_q <= S_T2M;
          end
        end
        S_T2M: begin
          state_q <= S_T2S;
        end
        S_T2S: begin
          div_req_q.start <= 1'b1;
          div_req_q.num   <= NumW'(unsigned'(mul_q));
          div_req_q.den   <= DenW'(rsum);
          state_q         <= S_T2;
        end
        S_T2: begin
          if (div_rsp.done) begin
            t2_q <= t2_w;
            t3_q <= t3_w;
            if (t1_q == '0 || t2_w == t1_q || t3_w == t2_w) begin
              fault_q <= 1'b1;
              state_q <= S_POS;
            end else begin
              div_req_q.start <= 1'b1;
              div_req_q.num   <= NumW'(abs25(sl_num)) << FRAC_BITS;
              div_req_q.den   <= DenW'(sl_den);
              slneg_q         <= sl_num[24];
              sl_q            <= 3'd0;
              state_q         <= S_SLP;
            end
          end
        end
        S_SLP: begin
          if (div_rsp.done) begin
            case (sl_q)
              3'd0:    kx1_q <= slope_w;
              3'd1:    kx2_q <= slope_w;
              3'd2:    kx3_q <= slope_w;
              3'd3:    ky1_q <= slope_w;
              default: ky2_q <= slope_w;
            endcase
            if (sl_q == 3'd4) begin
              state_q <= S_POS;
            end else begin
              div_req_q.start <= 1'b1;
              div_req_q.num   <= NumW'(abs25(sl_num)) << FRAC_BITS;
              div_req_q.den   <= DenW'(sl_den);
              slneg_q         <= sl_num[24];
              sl_q            <= sl_q + 3'd1;
            end
          end
        end
        S_PER: begin
          if (div_rsp.done) begin
            per_q <= per_w;
            if (per_w[23:1] == '0) begin
              fault_q <= 1'b1;
              state_q <= S_POS;
            end else begin
              div_req_q.start <= 1'b1;
              div_req_q.num   <= NumW'(dxm) << FRAC_BITS;
              div_req_q.den   <= DenW'(per_w[23:1]);
              slneg_q         <= d21[24];
              state_q         <= S_KE;
            end
          end
        end
        S_KE: begin
          if (div_rsp.done) begin
            k_q     <= slope_w;
            state_q <= S_POS;
          end
        end
        S_POS: begin
          if (fault_q) begin
            px_q    <= '0;
            py_q    <= '0;
            t_q     <= '0;
            seg_q   <= '0;
            state_q <= S_FIN;
          end else if (shape_q) begin
            t_q     <= t_ell;
            seg_q   <= {1'b0, seg_ell};
            state_q <= seg_ell ? S_PHM : S_MUL1;
          end else begin
            t_q     <= t_tri;
            seg_q   <= seg_tri;
            state_q <= S_MUL1;
          end
        end
        S_PHM: begin
          state_q <= S_PHS;
        end
        S_PHS: begin
          div_req_q.start <= 1'b1;
          div_req_q.num   <= NumW'(unsigned'(mul_q));
          div_req_q.den   <= DenW'(per_q);
          state_q         <= S_PHI;
        end
        S_PHI: begin
          if (div_rsp.done) begin
            cx_q    <= {2'b0, GainQ30};
            cy_q    <= '0;
            cz_q    <= theta;
            ci_q    <= '0;
            state_q <= S_CORD;
          end
        end
        S_CORD: begin
          if (!cz_q[AngW-1]) begin
            cx_q <= cx_q - cdx;
            cy_q <= cy_q + cdy;
            cz_q <= cz_q - cat;
          end else begin
            cx_q <= cx_q + cdx;
            cy_q <= cy_q - cdy;
            cz_q <= cz_q + cat;
          end
          if (ci_q == CiW'(CORDIC_STEPS - 1)) begin
            state_q <= S_MUL1;
          end else begin
            ci_q <= ci_q + 1'b1;
          end
        end
        S_MUL1: begin
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          px_q    <= sat_s24(x_sum);
          state_q <= S_MUL3;
        end
        S_MUL3: begin
          py_q    <= sat_s24(y_sum);
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_q || out_o.ready) begin
            out_q.pos_x     <= px_q;
            out_q.pos_y     <= py_q;
            out_q.time_used <= t_q;
            out_q.segment   <= seg_q;
            out_q.fault     <= fault_q;
            out_valid_q     <= 1'b1;
            state_q         <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready) else $error("second sample taken early");
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.fault) |->
      (out_o.data.pos_x == '0 && out_o.data.pos_y == '0 &&
       out_o.data.time_used == '0 && out_o.data.segment == '0))
    else $error("fault beat carries data");
  a_derived_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POS) |-> !recomp_q) else $error("position used stale timings");
  a_ellipse_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && shape_q) |-> (out_o.data.segment != 2'd2))
    else $error("ellipse route gave third segment");

endmodule

// ===== hdl/ftg_div.sv =====
module ftg_div import ftg_pkg::*; #(
  parameter int unsigned NUM_W = NumW,
  parameter int unsigned DEN_W = DenW
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(NUM_W);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;

  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W-1:0] rem_n;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  always_comb begin
    if (ge) begin
      rem_n = DEN_W'(trial - {1'b0, den_q});
    end else begin
      rem_n = trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NUM_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= NUM_W'(req_i.num);
      rem_q <= '0;
      den_q <= DEN_W'(req_i.den);
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= rem_n;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = NumW'(quo_q);

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("divider did not start");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.start && busy_q)) else $error("divider started while busy");
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == '0 && !req_i.start) |=> (done_q && !busy_q))
    else $error("divider did not finish");

endmodule

// ===== bench/ftg_trajectory_checker.sv =====
`timescale 1ns / 100ps

module ftg_trajectory_checker import ftg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_ready_i,
  input  ftg_in_t      in_data_i,
  input  logic         out_valid_i,
  input  logic         out_ready_i,
  input  ftg_out_t     out_data_i,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  ftg_cfg_t     cfg_data_i,
  output int unsigned  fail_count_o,
  output int unsigned  pending_o
);

  logic [23:0] regs [7];
  logic        stale;
  longint      end_t [3];
  longint      slp [5];
  longint      semi_a, semi_b, period, stroke_k;
  logic        bad_div;
  ftg_out_t    expected_q [$];

  function automatic longint sx(input logic [23:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint absl(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint satu(input longint v);
    if (v < 0) return 0;
    return v > 64'hFFFFFF ? 64'hFFFFFF : v;
  endfunction

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint slope_of(input longint num, input longint den);
    return sat32((num * 65536) / den);
  endfunction

  function automatic logic [23:0] sat_pos(input longint v);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  task automatic derive_route();
    longint x1, x2, x3, y1, y2, spd, dx, ra, rb, t1, t2, t3;
    x1 = sx(regs[RegX1]); x2 = sx(regs[RegX2]); x3 = sx(regs[RegX3]);
    y1 = sx(regs[RegY1]); y2 = sx(regs[RegY2]);
    spd = longint'(regs[RegSpeed]);
    dx = absl(x2 - x1);
    bad_div = 1'b0;
    if (spd == 0) begin
      bad_div = 1'b1;
      return;
    end
    if (regs[RegShape][0] == 1'b0) begin
      ra = absl(x3 - x2);
      rb = absl(x1 - x3);
      if (ra + rb == 0) begin
        bad_div = 1'b1;
        return;
      end
      t1 = satu(dx * 65536 / spd);
      t2 = satu(t1 + ra * t1 / (ra + rb));
      t3 = satu(2 * t1);
      end_t[0] = t1; end_t[1] = t2; end_t[2] = t3;
      if (t1 == 0 || t2 == t1 || t3 == t2) begin
        bad_div = 1'b1;
        return;
      end
      slp[0] = slope_of(x2 - x1, t1);
      slp[1] = slope_of(x3 - x2, t2 - t1);
      slp[2] = slope_of(x1 - x3, t3 - t2);
      slp[3] = slope_of(y2 - y1, t2 - t1);
      slp[4] = slope_of(y1 - y2, t3 - t2);
    end else begin
      semi_a = dx / 2;
      semi_b = absl(y2 - y1) & 64'hFFFFFF;
      period = satu(2 * dx * 65536 / spd);
      if ((period >>> 1) == 0) begin
        bad_div = 1'b1;
        return;
      end
      stroke_k = slope_of(x2 - x1, period >>> 1);
    end
  endtask

  task automatic rotate(input longint theta, output longint c, output longint s);
    longint x, y, z, ddx, ddy;
    x = longint'(GainQ30); y = 0; z = theta;
    for (int i = 0; i < CordicSteps; i++) begin
      ddx = y >>> i;
      ddy = x >>> i;
      if (z >= 0) begin
        x -= ddx; y += ddy; z -= longint'(atan_q30(5'(i)));
      end else begin
        x += ddx; y -= ddy; z += longint'(atan_q30(5'(i)));
      end
    end
    c = x;
    s = y;
  endtask

  task automatic predict_position(input logic [23:0] tin, output ftg_out_t r);
    longint t, x1, x2, x3, y1, y2, px, py, phi, c, s;
    logic [1:0] seg;
    t = longint'(tin);
    x1 = sx(regs[RegX1]); x2 = sx(regs[RegX2]); x3 = sx(regs[RegX3]);
    y1 = sx(regs[RegY1]); y2 = sx(regs[RegY2]);
    if (stale) begin
      derive_route();
      stale = 1'b0;
    end
    r = '0;
    if (bad_div) begin
      r.fault = 1'b1;
      return;
    end
    if (regs[RegShape][0] == 1'b0) begin
      if (t > end_t[2]) t = 0;
      if (t < end_t[0]) begin
        seg = 2'd0;
        px = x2 + ((slp[0] * (t - end_t[0])) >>> 16);
        py = y1;
      end else if (t < end_t[1]) begin
        seg = 2'd1;
        px = x3 + ((slp[1] * (t - end_t[1])) >>> 16);
        py = y2 + ((slp[3] * (t - end_t[1])) >>> 16);
      end else begin
        seg = 2'd2;
        px = x1 + ((slp[2] * (t - end_t[2])) >>> 16);
        py = y1 + ((slp[4] * (t - end_t[2])) >>> 16);
      end
    end else begin
      if (t > period) t = 0;
      if (2 * t < period) begin
        seg = 2'd0;
        px = x1 + ((stroke_k * t) >>> 16);
        py = y1;
      end else begin
        phi = longint'((64'(2 * t - period) * 64'(PiQ30)) / 64'(period));
        rotate(phi - longint'(HalfPiQ30), c, s);
        seg = 2'd1;
        px = x1 - semi_a + ((semi_a * s) >>> 30);
        py = y1 - ((semi_b * c) >>> 30);
      end
    end
    r.pos_x = sat_pos(px);
    r.pos_y = sat_pos(py);
    r.time_used = t[23:0];
    r.segment = seg;
  endtask

  assign pending_o = expected_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    ftg_out_t r;
    if (!rst_ni) begin
      for (int i = 0; i < 7; i++) regs[i] <= (i == int'(RegSpeed)) ? SpeedReset : 24'd0;
      stale = 1'b1;
      bad_div = 1'b0;
      fail_count_o <= 0;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i && cfg_data_i.index < 7) begin
        regs[cfg_data_i.index] <= cfg_data_i.index == RegShape ?
                                  24'(cfg_data_i.value[0]) : cfg_data_i.value;
        stale = 1'b1;
      end
      if (in_valid_i && in_ready_i) begin
        predict_position(in_data_i.time_now, r);
        expected_q.push_back(r);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected result beat %p", out_data_i);
        end else begin
          r = expected_q.pop_front();
          if (r !== out_data_i) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("mismatch: expected %p, got %p", r, out_data_i);
          end
        end
      end
    end
  end

endmodule

// ===== bench/tb_foot_trajectory_generator.sv =====
`timescale 1ns / 100ps

module tb_foot_trajectory_generator;
  import ftg_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  longint      cycles;
  logic        hold_off;
  logic        hold_req;

  ftg_stream_if #(.payload_t(ftg_in_t))  in_if ();
  ftg_stream_if #(.payload_t(ftg_out_t)) out_if ();
  ftg_stream_if #(.payload_t(ftg_cfg_t)) cfg_if ();

  foot_trajectory_generator dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  ftg_trajectory_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_i  (in_if.ready),
    .in_data_i   (in_if.data),
    .out_valid_i (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_i  (out_if.data),
    .cfg_valid_i (cfg_if.valid),
    .cfg_ready_i (cfg_if.ready),
    .cfg_data_i  (cfg_if.data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 3000000) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int mode;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) out_if.ready <= 1'b0;
      else begin
        mode = int'((cycles / 2000) % 3);
        if (mode == 0) out_if.ready <= 1'b1;
        else if (mode == 1) out_if.ready <= ($urandom_range(0, 3) != 0);
        else out_if.ready <= ($urandom_range(0, 1) == 0);
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [23:0] val);
    cfg_if.data <= '{index: idx, value: val};
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_time(input logic [23:0] t);
    in_if.data <= '{time_now: t};
    in_if.valid <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic gap();
    if ($urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic load_route(input logic shape, input logic [23:0] x1, input logic [23:0] x2,
                            input logic [23:0] x3, input logic [23:0] y1,
                            input logic [23:0] y2, input logic [23:0] spd);
    write_reg(RegShape, 24'(shape));
    write_reg(RegX1, x1);
    write_reg(RegX2, x2);
    write_reg(RegX3, x3);
    write_reg(RegY1, y1);
    write_reg(RegY2, y2);
    write_reg(RegSpeed, spd);
  endtask

  function automatic logic [23:0] rand_time(input int span);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 24'($urandom());
    if (r == 1) return 24'(span);
    return 24'($urandom_range(0, span + span / 8));
  endfunction

  initial begin
    int span;
    logic [23:0] tri_pts [7];
    logic [23:0] ell_pts [6];
    hold_req = 1'b0;
    rst_ni = 1'b0;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    tri_pts = '{24'd0, 24'd65535, 24'd131072, 24'd196608, 24'd262144, 24'd262145,
                24'hFFFFFF};
    ell_pts = '{24'd0, 24'd65535, 24'd65536, 24'd98304, 24'd131072, 24'd131073};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_time(24'd0);
    send_time(24'hFFFFFF);
    drain();
    load_route(1'b0, 24'hFF0000, 24'h010000, 24'h000000, 24'h000000, 24'h008000, 24'h010000);
    foreach (tri_pts[i])
      send_time(tri_pts[i]);
    drain();
    write_reg(RegSpeed, 24'd0);
    send_time(24'd100);
    drain();
    write_reg(RegSpeed, 24'hFFFFFF);
    write_reg(RegX3, 24'h010000);
    send_time(24'd3);
    drain();
    load_route(1'b1, 24'h800000, 24'h7FFFFF, 24'h0, 24'h800000, 24'h7FFFFF, 24'h010000);
    send_time(24'd0);
    send_time(24'hFFFFFF);
    drain();
    load_route(1'b1, 24'hFF0000, 24'h010000, 24'h0, 24'h000000, 24'h010000, 24'h020000);
    foreach (ell_pts[i])
      send_time(ell_pts[i]);
    drain();

    for (int ph = 0; ph < 16; ph++) begin
      logic [23:0] x1, x2, spd;
      x1 = ($urandom_range(0, 7) == 0) ? 24'($urandom())
                                       : 24'(int'($urandom_range(0, 262144)) - 131072);
      x2 = ($urandom_range(0, 7) == 0) ? 24'($urandom())
                                       : 24'(int'($urandom_range(0, 262144)) - 131072);
      spd = ($urandom_range(0, 9) == 0) ? 24'($urandom()) : 24'($urandom_range(16384, 262144));
      load_route(ph[0], x1, x2, 24'($urandom()), 24'($urandom()), 24'($urandom()), spd);
      span = 1 << 20;
      for (int n = 0; n < 50; n++) begin
        if (ph == 5 && n == 10) hold_req = 1'b1;
        send_time(rand_time(span));
        gap();
      end
      drain();
    end
    load_route(1'b0, 24'h7FFFFF, 24'h800000, 24'h000000, 24'h7FFFFF, 24'h800000, 24'h000001);
    send_time(24'h000100);
    drain();

    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    hold_off = 1'b0;
    @(posedge hold_req);
    hold_off = 1'b1;
    repeat (400) @(negedge clk_i);
    hold_off = 1'b0;
  end

endmodule

// ===== foot_trajectory_generator.f =====
hdl/ftg_pkg.sv
hdl/ftg_stream_if.sv
hdl/ftg_div.sv
hdl/foot_trajectory_generator.sv
bench/ftg_trajectory_checker.sv
bench/tb_foot_trajectory_generator.sv
